### rtl/hq_pkg.sv
// Shared types and constants for the heightmap height query block.
// Used by every module under rtl; depends on nothing.
package hq_pkg;

    localparam int CELLS_W   = 7;
    localparam int CS_W      = 20;
    localparam int H_W       = 24;
    localparam int XY_W      = 32;
    localparam int FLAT_W    = 16;
    localparam int DIV_W     = 48;
    localparam int Q_W       = CS_W + 1;
    localparam int WH_W      = CELLS_W + CS_W;
    localparam int P_W       = H_W + Q_W + 2;
    localparam int CFG_IDX_W = 2;

    localparam int CELLS_RESET     = 64;
    localparam int CELL_SIZE_RESET = 12800;
    localparam int H_MAX           = 2 ** (H_W - 1) - 1;
    localparam int H_MIN           = -(2 ** (H_W - 1));

    localparam logic [CFG_IDX_W-1:0] CFG_ROW_CELLS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COL_CELLS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CELL_SIZE = 2'd2;

    typedef enum logic {
        FUNC_WRITE = 1'b0,
        FUNC_QUERY = 1'b1
    } func_t;

    typedef struct packed {
        logic [CELLS_W-1:0] row_cells;
        logic [CELLS_W-1:0] col_cells;
        logic [CS_W-1:0]    cell_size;
    } hq_cfg_t;

    typedef struct packed {
        logic                   query;
        logic                   wr_ok;
        logic [FLAT_W-1:0]      wr_addr;
        logic signed [H_W-1:0]  height;
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] z;
    } hq_item_t;

    typedef struct packed {
        logic signed [DIV_W-1:0] quot;
        logic [Q_W-1:0]          rem;
    } hq_floor_t;

    typedef struct packed {
        logic              ok;
        logic [FLAT_W-1:0] idx;
    } hq_corner_t;

    typedef enum logic [3:0] {
        B_IDLE,
        B_START,
        B_DIV,
        B_FLOOR,
        B_ADDR,
        B_READ,
        B_MUL,
        B_SUM,
        B_START2,
        B_DIV2,
        B_FIN,
        B_OUT
    } hq_back_state_t;

endpackage

### rtl/hq_front.sv
// Front end: accepts input words, classifies writes against the grid and
// holds them in a two-entry queue for the back end. Depends on hq_pkg.
module hq_front (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  hq_pkg::hq_cfg_t               cfg,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_func,
    input  logic [hq_pkg::CELLS_W-1:0]    s_vertex_row,
    input  logic [hq_pkg::CELLS_W-1:0]    s_vertex_col,
    input  logic signed [hq_pkg::H_W-1:0] s_vertex_height,
    input  logic signed [hq_pkg::XY_W-1:0] s_query_x,
    input  logic signed [hq_pkg::XY_W-1:0] s_query_z,
    output hq_pkg::hq_item_t              q_item,
    output logic                          q_valid,
    input  logic                          q_pop
);
    import hq_pkg::*;

    hq_item_t         buf_reg [2];
    logic             wr_ptr_reg, wr_ptr_next;
    logic             rd_ptr_reg, rd_ptr_next;
    logic [1:0]       cnt_reg, cnt_next;
    logic             push;
    logic [FLAT_W-1:0] stride;
    logic [FLAT_W-1:0] prod;
    hq_item_t         item;

    assign s_ready = (cnt_reg != 2'd2);
    assign push    = s_valid && s_ready;
    assign q_valid = (cnt_reg != 2'd0);
    assign q_item  = buf_reg[rd_ptr_reg];

    always_comb begin
        stride       = FLAT_W'(cfg.col_cells) + FLAT_W'(1);
        prod         = FLAT_W'(s_vertex_row) * stride;
        item.query   = (s_func == FUNC_QUERY);
        item.wr_ok   = (s_vertex_row <= cfg.row_cells) && (s_vertex_col <= cfg.col_cells);
        item.wr_addr = prod + FLAT_W'(s_vertex_col);
        item.height  = s_vertex_height;
        item.x       = s_query_x;
        item.z       = s_query_z;
    end

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = q_pop ? ~rd_ptr_reg : rd_ptr_reg;
        case ({push, q_pop})
            2'b10:   cnt_next = cnt_reg + 2'd1;
            2'b01:   cnt_next = cnt_reg - 2'd1;
            default: cnt_next = cnt_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            buf_reg[wr_ptr_reg] <= item;
        end
    end

endmodule

### rtl/hq_div.sv
// Unsigned restoring divider, two quotient bits per cycle.
// Depends on hq_pkg for the dividend and divisor widths.
module hq_div (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic [hq_pkg::DIV_W-1:0]   dividend,
    input  logic [hq_pkg::Q_W-1:0]     divisor,
    output logic                       done,
    output logic [hq_pkg::DIV_W-1:0]   quot,
    output logic [hq_pkg::Q_W-1:0]     rem
);
    import hq_pkg::*;

    localparam int STEPS = DIV_W / 2;
    localparam int CNT_W = $clog2(STEPS);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [DIV_W-1:0] quo_reg;
    logic [Q_W-1:0]   rem_reg;
    logic [Q_W-1:0]   d_reg;
    logic [DIV_W-1:0] quo_step;
    logic [Q_W-1:0]   rem_step;
    logic [Q_W:0]     trial;

    assign done = done_reg;
    assign quot = quo_reg;
    assign rem  = rem_reg;

    always_comb begin
        rem_step = rem_reg;
        quo_step = quo_reg;
        trial    = '0;
        for (int i = 0; i < 2; i++) begin
            trial    = {rem_step, quo_step[DIV_W-1]};
            quo_step = {quo_step[DIV_W-2:0], 1'b0};
            if (trial >= {1'b0, d_reg}) begin
                trial       = trial - {1'b0, d_reg};
                quo_step[0] = 1'b1;
            end
            rem_step = trial[Q_W-1:0];
        end
    end

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
        end else if (busy_reg) begin
            cnt_next = cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(STEPS - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= dividend;
            rem_reg <= '0;
            d_reg   <= divisor;
        end else if (busy_reg) begin
            quo_reg <= quo_step;
            rem_reg <= rem_step;
        end
    end

endmodule

### rtl/hq_back.sv
// Back end: owns the height store and runs each queued word through grid
// mapping, corner reads and interpolation. Depends on hq_pkg and hq_div.
module hq_back #(
    parameter int MAX_CELLS = 64
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  hq_pkg::hq_cfg_t               cfg,
    input  hq_pkg::hq_item_t              q_item,
    input  logic                          q_valid,
    output logic                          q_pop,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [hq_pkg::H_W-1:0] m_height_out
);
    import hq_pkg::*;

    localparam int DEPTH = (MAX_CELLS + 1) * (MAX_CELLS + 1);
    localparam int AW    = $clog2(DEPTH);

    hq_back_state_t state_reg, state_next;
    logic [2:0]     rd_cnt_reg, rd_cnt_next;
    logic           m_valid_reg, m_valid_next;
    logic signed [H_W-1:0] m_height_reg;

    logic signed [H_W-1:0] mem [DEPTH];
    logic signed [H_W-1:0] rd_data_reg;
    logic [AW-1:0]         rd_idx;
    logic                  mem_we;

    logic signed [DIV_W-1:0] dvd_x_reg, dvd_z_reg;
    logic [Q_W-1:0]          q_reg;
    logic signed [DIV_W-1:0] row_reg, col_reg;
    logic [Q_W-1:0]          rx_reg, rz_reg;
    hq_corner_t              cr_reg [4];
    logic signed [H_W-1:0]   corner_reg [4];
    logic signed [P_W-1:0]   p1_reg, p2_reg;
    logic signed [H_W-1:0]   base_reg;
    logic signed [H_W-1:0]   res_reg;

    logic [WH_W-1:0]         w, h;
    logic signed [DIV_W-1:0] nx, nz;
    logic [DIV_W-1:0]        mag_x, mag_z;
    logic                    start_x, start_z;
    logic                    done_x, done_z;
    logic [DIV_W-1:0]        quot_x, quot_z;
    logic [Q_W-1:0]          rem_x, rem_z;
    hq_floor_t               fx, fz;
    logic [CELLS_W:0]        stride;
    logic [FLAT_W-1:0]       size;
    hq_corner_t              cr_new [4];
    logic [1:0]              prev;
    logic                    tri_abc;
    logic signed [H_W:0]     f1, f2;
    logic [Q_W-1:0]          m1, m2;
    logic signed [P_W-1:0]   p1, p2;
    logic signed [H_W-1:0]   base;
    logic signed [DIV_W-1:0] num;
    logic signed [DIV_W:0]   total;
    logic signed [H_W-1:0]   res_sat;

    function automatic hq_floor_t floor_fix(input logic neg, input logic [DIV_W-1:0] qa,
                                            input logic [Q_W-1:0] ra, input logic [Q_W-1:0] d);
        hq_floor_t f;
        if (neg && ra != '0) begin
            f.quot = -$signed(qa) - DIV_W'(1);
            f.rem  = d - ra;
        end else if (neg) begin
            f.quot = -$signed(qa);
            f.rem  = '0;
        end else begin
            f.quot = $signed(qa);
            f.rem  = ra;
        end
        return f;
    endfunction

    // A corner is valid when its row and column are not negative and its
    // flat index lies inside the configured grid.
    function automatic hq_corner_t corner_addr(input logic signed [DIV_W-1:0] row,
                                               input logic signed [DIV_W-1:0] col,
                                               input logic [CELLS_W-1:0] rows,
                                               input logic [CELLS_W:0] strd,
                                               input logic [FLAT_W-1:0] sz);
        hq_corner_t    cr;
        logic [FLAT_W:0] flat;
        flat   = (FLAT_W + 1)'(FLAT_W'(row[CELLS_W-1:0]) * FLAT_W'(strd))
               + (FLAT_W + 1)'(col[FLAT_W-1:0]);
        cr.ok  = !row[DIV_W-1] && !col[DIV_W-1]
               && (row[DIV_W-2:0] <= (DIV_W - 1)'(rows))
               && (col[DIV_W-2:0] < (DIV_W - 1)'(sz))
               && (flat < {1'b0, sz});
        cr.idx = flat[FLAT_W-1:0];
        return cr;
    endfunction

    hq_div u_div_x (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (start_x),
        .dividend (mag_x),
        .divisor  (q_reg),
        .done     (done_x),
        .quot     (quot_x),
        .rem      (rem_x)
    );

    hq_div u_div_z (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (start_z),
        .dividend (mag_z),
        .divisor  (q_reg),
        .done     (done_z),
        .quot     (quot_z),
        .rem      (rem_z)
    );

    assign m_valid      = m_valid_reg;
    assign m_height_out = m_height_reg;

    // Grid mapping, corner addressing and interpolation datapath.
    always_comb begin
        w      = WH_W'(cfg.col_cells) * WH_W'(cfg.cell_size);
        h      = WH_W'(cfg.row_cells) * WH_W'(cfg.cell_size);
        nx     = {{(DIV_W - XY_W - 1){q_item.x[XY_W-1]}}, q_item.x, 1'b0} + DIV_W'(w);
        nz     = DIV_W'(h) - {{(DIV_W - XY_W - 1){q_item.z[XY_W-1]}}, q_item.z, 1'b0};
        mag_x  = dvd_x_reg[DIV_W-1] ? DIV_W'(-dvd_x_reg) : DIV_W'(dvd_x_reg);
        mag_z  = dvd_z_reg[DIV_W-1] ? DIV_W'(-dvd_z_reg) : DIV_W'(dvd_z_reg);
        fx     = floor_fix(dvd_x_reg[DIV_W-1], quot_x, rem_x, q_reg);
        fz     = floor_fix(dvd_z_reg[DIV_W-1], quot_z, rem_z, q_reg);
        stride = (CELLS_W + 1)'(cfg.col_cells) + (CELLS_W + 1)'(1);
        size   = FLAT_W'(stride) * (FLAT_W'(cfg.row_cells) + FLAT_W'(1));
        cr_new[0] = corner_addr(row_reg, col_reg, cfg.row_cells, stride, size);
        cr_new[1] = corner_addr(row_reg, col_reg + DIV_W'(1), cfg.row_cells, stride, size);
        cr_new[2] = corner_addr(row_reg + DIV_W'(1), col_reg, cfg.row_cells, stride, size);
        cr_new[3] = corner_addr(row_reg + DIV_W'(1), col_reg + DIV_W'(1),
                                cfg.row_cells, stride, size);
        prev    = rd_cnt_reg[1:0] - 2'd1;
        tri_abc = ({1'b0, rx_reg} + {1'b0, rz_reg}) < {1'b0, q_reg};
        if (tri_abc) begin
            f1   = {corner_reg[1][H_W-1], corner_reg[1]} - {corner_reg[0][H_W-1], corner_reg[0]};
            f2   = {corner_reg[2][H_W-1], corner_reg[2]} - {corner_reg[0][H_W-1], corner_reg[0]};
            m1   = rx_reg;
            m2   = rz_reg;
            base = corner_reg[0];
        end else begin
            f1   = {corner_reg[2][H_W-1], corner_reg[2]} - {corner_reg[3][H_W-1], corner_reg[3]};
            f2   = {corner_reg[1][H_W-1], corner_reg[1]} - {corner_reg[3][H_W-1], corner_reg[3]};
            m1   = q_reg - rx_reg;
            m2   = q_reg - rz_reg;
            base = corner_reg[3];
        end
        p1    = f1 * $signed({1'b0, m1});
        p2    = f2 * $signed({1'b0, m2});
        num   = DIV_W'(p1_reg) + DIV_W'(p2_reg) + $signed(DIV_W'(cfg.cell_size));
        total = (DIV_W + 1)'(base_reg) + (DIV_W + 1)'(fx.quot);
        if (total > H_MAX) begin
            res_sat = H_W'(H_MAX);
        end else if (total < H_MIN) begin
            res_sat = H_W'(H_MIN);
        end else begin
            res_sat = total[H_W-1:0];
        end
    end

    always_comb begin
        state_next   = state_reg;
        rd_cnt_next  = rd_cnt_reg;
        m_valid_next = m_valid_reg && !m_ready;
        q_pop        = 1'b0;
        start_x      = 1'b0;
        start_z      = 1'b0;
        mem_we       = 1'b0;
        rd_idx       = AW'(cr_reg[rd_cnt_reg[1:0]].idx);
        case (state_reg)
            B_IDLE: begin
                if (q_valid) begin
                    q_pop = 1'b1;
                    if (q_item.query) begin
                        state_next = B_START;
                    end else begin
                        mem_we     = q_item.wr_ok;
                        state_next = B_OUT;
                    end
                end
            end
            B_START: begin
                start_x    = 1'b1;
                start_z    = 1'b1;
                state_next = B_DIV;
            end
            B_DIV: begin
                if (done_x && done_z) begin
                    state_next = B_FLOOR;
                end
            end
            B_FLOOR: state_next = B_ADDR;
            B_ADDR: begin
                rd_cnt_next = 3'd0;
                state_next  = B_READ;
            end
            B_READ: begin
                rd_cnt_next = rd_cnt_reg + 3'd1;
                if (rd_cnt_reg == 3'd4) begin
                    state_next = B_MUL;
                end
            end
            B_MUL:    state_next = B_SUM;
            B_SUM:    state_next = B_START2;
            B_START2: begin
                start_x    = 1'b1;
                state_next = B_DIV2;
            end
            B_DIV2: begin
                if (done_x) begin
                    state_next = B_FIN;
                end
            end
            B_FIN:    state_next = B_OUT;
            B_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    state_next   = B_IDLE;
                end
            end
            default:  state_next = B_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= B_IDLE;
            rd_cnt_reg  <= 3'd0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            rd_cnt_reg  <= rd_cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[AW'(q_item.wr_addr)] <= q_item.height;
        end
        rd_data_reg <= mem[rd_idx];
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            B_IDLE: begin
                dvd_x_reg <= nx;
                dvd_z_reg <= nz;
                q_reg     <= {cfg.cell_size, 1'b0};
                res_reg   <= '0;
            end
            B_FLOOR: begin
                col_reg <= fx.quot;
                rx_reg  <= fx.rem;
                row_reg <= fz.quot;
                rz_reg  <= fz.rem;
            end
            B_ADDR: begin
                for (int i = 0; i < 4; i++) begin
                    cr_reg[i] <= cr_new[i];
                end
            end
            B_READ: begin
                if (rd_cnt_reg != 3'd0) begin
                    corner_reg[prev] <= cr_reg[prev].ok ? rd_data_reg : '0;
                end
            end
            B_MUL: begin
                p1_reg   <= p1;
                p2_reg   <= p2;
                base_reg <= base;
            end
            B_SUM:   dvd_x_reg <= num;
            B_FIN:   res_reg   <= res_sat;
            B_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_height_reg <= res_reg;
                end
            end
            default: ;
        endcase
    end

endmodule

### rtl/heightmap_height_query.sv
// Heightmap height query, top level.
// The s_ channel takes one word per item. With func low the word writes one
// vertex height into the grid store; with func high it asks for the height
// at world position (query_x, query_z), signed Q24.8.
// The m_ channel returns one word per item: the interpolated height, signed
// Q16.8, saturated, or zero for a vertex write.
// The cfg port writes row_cells (0), col_cells (1) and cell_size (2);
// cell counts saturate to 1..MAX_CELLS and a zero cell size reads as 1.
// Write only while no item is in flight.
// A two-word queue decouples input from the working back end, so input is
// taken while a query is computed or a result waits.
// The back end takes one item at a time and pops the next word only in idle.
// A vertex write goes from idle straight to the output state. A query runs
// two radix-4 divider passes, four reads through the single read port of the
// height store and the sequencing states between them.
// Reset clears the queue, the sequencer and the result valid flag and loads
// the configuration defaults; the height store is not cleared and must be
// written before it is read. When m_ready is low the result holds and the
// back end waits, while the queue keeps filling.
module heightmap_height_query #(
    parameter int MAX_CELLS = 64
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_we,
    input  logic [hq_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [hq_pkg::CS_W-1:0]        cfg_wdata,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic                           s_func,
    input  logic [hq_pkg::CELLS_W-1:0]     s_vertex_row,
    input  logic [hq_pkg::CELLS_W-1:0]     s_vertex_col,
    input  logic signed [hq_pkg::H_W-1:0]  s_vertex_height,
    input  logic signed [hq_pkg::XY_W-1:0] s_query_x,
    input  logic signed [hq_pkg::XY_W-1:0] s_query_z,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic signed [hq_pkg::H_W-1:0]  m_height_out
);
    import hq_pkg::*;

    localparam logic [CELLS_W-1:0] CELLS_DEF =
        CELLS_W'((MAX_CELLS < CELLS_RESET) ? MAX_CELLS : CELLS_RESET);

    hq_cfg_t          cfg_reg, cfg_next;
    hq_item_t         q_item;
    logic             q_valid;
    logic             q_pop;
    logic [CELLS_W-1:0] cells_sat;

    always_comb begin
        if (cfg_wdata[CELLS_W-1:0] == '0) begin
            cells_sat = CELLS_W'(1);
        end else if (int'(cfg_wdata[CELLS_W-1:0]) > MAX_CELLS) begin
            cells_sat = CELLS_W'(MAX_CELLS);
        end else begin
            cells_sat = cfg_wdata[CELLS_W-1:0];
        end
        cfg_next = cfg_reg;
        if (cfg_we) begin
            case (cfg_index)
                CFG_ROW_CELLS: cfg_next.row_cells = cells_sat;
                CFG_COL_CELLS: cfg_next.col_cells = cells_sat;
                CFG_CELL_SIZE: cfg_next.cell_size = (cfg_wdata == '0) ? CS_W'(1) : cfg_wdata;
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.row_cells <= CELLS_DEF;
            cfg_reg.col_cells <= CELLS_DEF;
            cfg_reg.cell_size <= CS_W'(CELL_SIZE_RESET);
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    hq_front u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg             (cfg_reg),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_func          (s_func),
        .s_vertex_row    (s_vertex_row),
        .s_vertex_col    (s_vertex_col),
        .s_vertex_height (s_vertex_height),
        .s_query_x       (s_query_x),
        .s_query_z       (s_query_z),
        .q_item          (q_item),
        .q_valid         (q_valid),
        .q_pop           (q_pop)
    );

    hq_back #(
        .MAX_CELLS (MAX_CELLS)
    ) u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg          (cfg_reg),
        .q_item       (q_item),
        .q_valid      (q_valid),
        .q_pop        (q_pop),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_height_out (m_height_out)
    );

`ifndef SYNTH
    a_no_result_after_reset: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result word valid right after reset");
    a_pop_needs_word: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> q_valid)
        else $error("back end popped an empty queue");
    a_cells_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_reg.row_cells != '0 && cfg_reg.col_cells != '0
        && int'(cfg_reg.row_cells) <= MAX_CELLS && int'(cfg_reg.col_cells) <= MAX_CELLS)
        else $error("grid cell count out of range");
    a_cell_size_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_reg.cell_size != '0)
        else $error("cell size is zero");
`endif

endmodule
